// ----- design/sawcf_pkg.sv -----
package sawcf_pkg;

   // command codes
   localparam logic [2:0] CMD_START   = 3'd0;
   localparam logic [2:0] CMD_PAYLOAD = 3'd1;
   localparam logic [2:0] CMD_PULL    = 3'd2;
   localparam logic [2:0] CMD_ACK     = 3'd3;
   localparam logic [2:0] CMD_TICK    = 3'd4;

   // phase codes, also reported as status
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LOADING = 3'd1;
   localparam logic [2:0] ST_SENDING = 3'd2;
   localparam logic [2:0] ST_AWAIT   = 3'd3;
   localparam logic [2:0] ST_BACKOFF = 3'd4;
   localparam logic [2:0] ST_ACKED   = 3'd5;
   localparam logic [2:0] ST_FAILED  = 3'd6;
   localparam logic [2:0] ST_REJECT  = 3'd7;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_ATTEMPTS   = 2'd0;
   localparam logic [1:0] CSR_ACK_TIMEOUT    = 2'd1;
   localparam logic [1:0] CSR_BACKOFF        = 2'd2;
   localparam logic [1:0] CSR_TELEMETRY_SEQ  = 2'd3;

   localparam logic [5:0]  CFG_RESET_MAX_ATTEMPTS = 6'd50;
   localparam logic [12:0] CFG_RESET_ACK_TIMEOUT  = 13'd5000;
   localparam logic [9:0]  CFG_RESET_BACKOFF      = 10'd100;
   localparam logic [7:0]  CFG_RESET_TELEMETRY_SEQ = 8'd255;

   localparam int HEADER_BYTES  = 3;
   localparam int TRAILER_BYTES = 4;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       packet_kind;
      logic [7:0] chunk_total;
      logic [7:0] ack_sequence;
      logic       ack_good;
   } item_type;

   typedef struct packed {
      logic [5:0]  max_attempts;
      logic [12:0] ack_timeout_ticks;
      logic [9:0]  backoff_ticks;
      logic [7:0]  telemetry_sequence;
   } cfg_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [2:0] status;
      logic [5:0] attempt_number;
      logic [7:0] next_sequence;
   } result_type;

   typedef logic [31:0] crc_tab_type [256];

   // entry i: reflected CRC of byte i followed by zero_bytes zero bytes, from state 0
   function automatic crc_tab_type crc_tab_gen(input int unsigned zero_bytes);
      crc_tab_type t;
      logic [31:0] c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8 * (zero_bytes + 1); k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_tab_type CRC_TAB0 = crc_tab_gen(0);
   localparam crc_tab_type CRC_TAB1 = crc_tab_gen(1);
   localparam crc_tab_type CRC_TAB2 = crc_tab_gen(2);
   localparam crc_tab_type CRC_TAB3 = crc_tab_gen(3);

endpackage

// ----- design/stop_and_wait_crc_framer_top.sv -----
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  cmd, data_byte, last_byte, packet_kind,
//                                          chunk_total, ack_sequence, ack_good
// rsp      out        rsp_valid/rsp_stall  tx_valid, tx_byte, tx_last, status,
//                                          attempt_number, next_sequence
// csr      in         csr_write_enable     csr_index, csr_write_data
//
// One item per cycle unless a stalled result holds the input register: an accepted
// item sits in the input register, is executed against the frame state and lands
// in the result register when it advances. Frame CRC is done by table slices as
// the item executes. Reset (synchronous) clears the frame state and loads the register
// defaults; the payload store is not cleared. A stalled result holds, and req_stall
// rises only when both the input and result registers are full.
module stop_and_wait_crc_framer_top #(
   parameter int MAX_PAYLOAD  = 100,
   parameter int BUFFER_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        req_packet_kind,
   input  logic [7:0]  req_chunk_total,
   input  logic [7:0]  req_ack_sequence,
   input  logic        req_ack_good,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_attempt_number,
   output logic [7:0]  rsp_next_sequence,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_write_data
);
   import sawcf_pkg::*;

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result_ff, result_in;
   logic       rsp_valid_ff;
   logic       req_take, advance;

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   sawcf_core #(
      .MAX_PAYLOAD  (MAX_PAYLOAD),
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts       <= CFG_RESET_MAX_ATTEMPTS;
         cfg_ff.ack_timeout_ticks  <= CFG_RESET_ACK_TIMEOUT;
         cfg_ff.backoff_ticks      <= CFG_RESET_BACKOFF;
         cfg_ff.telemetry_sequence <= CFG_RESET_TELEMETRY_SEQ;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_ATTEMPTS:  cfg_ff.max_attempts       <= csr_write_data[5:0];
            CSR_ACK_TIMEOUT:   cfg_ff.ack_timeout_ticks  <= csr_write_data;
            CSR_BACKOFF:       cfg_ff.backoff_ticks      <= csr_write_data[9:0];
            CSR_TELEMETRY_SEQ: cfg_ff.telemetry_sequence <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cmd          <= req_cmd;
         item_ff.data_byte    <= req_data_byte;
         item_ff.last_byte    <= req_last_byte;
         item_ff.packet_kind  <= req_packet_kind;
         item_ff.chunk_total  <= req_chunk_total;
         item_ff.ack_sequence <= req_ack_sequence;
         item_ff.ack_good     <= req_ack_good;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tx_valid       = result_ff.tx_valid;
   assign rsp_tx_byte        = result_ff.tx_byte;
   assign rsp_tx_last        = result_ff.tx_last;
   assign rsp_status         = result_ff.status;
   assign rsp_attempt_number = result_ff.attempt_number;
   assign rsp_next_sequence  = result_ff.next_sequence;

endmodule

// ----- design/sawcf_core.sv -----
module sawcf_core #(
   parameter int MAX_PAYLOAD  = 100,
   parameter int BUFFER_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  sawcf_pkg::item_type   item,
   input  sawcf_pkg::cfg_type    cfg,
   output sawcf_pkg::result_type result
);
   import sawcf_pkg::*;

   localparam int CAP = (MAX_PAYLOAD < BUFFER_DEPTH - 7) ? MAX_PAYLOAD : BUFFER_DEPTH - 7;
   localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int PLW = $clog2(CAP + 1);
   localparam int RPW = $clog2(CAP + HEADER_BYTES + TRAILER_BYTES + 1);

   // payload bytes only; header and CRC bytes live in registers
   logic [7:0] store_mem [CAP];
   logic [7:0] rd_data_ff;

   logic [2:0]     phase_ff, phase_in;
   logic [PLW-1:0] pl_ff, pl_in;
   logic [RPW-1:0] rp_ff, rp_in;
   logic [31:0]    crc_ff, crc_in;
   logic [5:0]     attempt_ff, attempt_in;
   logic [12:0]    wait_ff, wait_in;
   logic [7:0]     file_seq_ff, file_seq_in;
   logic [7:0]     frame_seq_ff, frame_seq_in;
   logic           tele_ff, tele_in;
   logic [7:0]     total_ff, total_in;

   logic           free;
   logic [PLW-1:0] pl_base;
   logic [7:0]     seq_new, total_new;
   logic [31:0]    start_word, start_crc, byte_crc;
   logic [RPW-1:0] frame_len, hdr_pl_end, rp_step, crc_off, rd_ptr_off;
   logic [1:0]     crc_idx;
   logic [31:0]    crc_out;
   logic [7:0]     pull_byte;
   logic [12:0]    wait_step;
   logic           wr_en, reject, fail_attempt, do_resend;
   logic           tx_valid, tx_last;
   logic [7:0]     tx_byte;

   assign free = (phase_ff == ST_IDLE) || (phase_ff == ST_ACKED) || (phase_ff == ST_FAILED);
   assign pl_base = free ? '0 : pl_ff;
   assign seq_new = item.packet_kind ? cfg.telemetry_sequence : file_seq_ff;
   assign total_new = item.packet_kind ? 8'd0 : item.chunk_total;

   // header plus first payload byte in one pass, four table slices
   assign start_word = CRC_PRESET ^ {item.data_byte, total_new, seq_new, 7'd0, item.packet_kind};
   assign start_crc = CRC_TAB3[start_word[7:0]] ^ CRC_TAB2[start_word[15:8]]
                    ^ CRC_TAB1[start_word[23:16]] ^ CRC_TAB0[start_word[31:24]];
   assign byte_crc = (crc_ff >> 8) ^ CRC_TAB0[crc_ff[7:0] ^ item.data_byte];

   assign frame_len  = RPW'(pl_ff) + RPW'(HEADER_BYTES + TRAILER_BYTES);
   assign hdr_pl_end = RPW'(pl_ff) + RPW'(HEADER_BYTES);
   assign rp_step    = rp_ff + RPW'(1);
   assign crc_off    = rp_ff - hdr_pl_end;
   assign crc_idx    = crc_off[1:0];
   assign crc_out    = ~crc_ff;
   assign wait_step  = wait_ff + 13'd1;

   always_comb begin
      if (rp_ff < RPW'(HEADER_BYTES)) begin
         unique case (rp_ff[1:0])
            2'd0:    pull_byte = {7'd0, tele_ff};
            2'd1:    pull_byte = frame_seq_ff;
            2'd2:    pull_byte = total_ff;
            default: pull_byte = 8'd0;
         endcase
      end else if (rp_ff < hdr_pl_end) begin
         pull_byte = rd_data_ff;
      end else begin
         pull_byte = crc_out[{crc_idx, 3'b000} +: 8];
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      pl_in        = pl_ff;
      rp_in        = rp_ff;
      crc_in       = crc_ff;
      attempt_in   = attempt_ff;
      wait_in      = wait_ff;
      file_seq_in  = file_seq_ff;
      frame_seq_in = frame_seq_ff;
      tele_in      = tele_ff;
      total_in     = total_ff;
      wr_en        = 1'b0;
      reject       = 1'b0;
      fail_attempt = 1'b0;
      do_resend    = 1'b0;
      tx_valid     = 1'b0;
      tx_byte      = 8'd0;
      tx_last      = 1'b0;
      if (fire) begin
         unique case (item.cmd)
            CMD_START: begin
               if (free) begin
                  file_seq_in = 8'd0;
                  phase_in    = ST_IDLE;
               end else begin
                  reject = 1'b1;
               end
            end
            CMD_PAYLOAD: begin
               if (free || phase_ff == ST_LOADING) begin
                  if (free) begin
                     tele_in      = item.packet_kind;
                     frame_seq_in = seq_new;
                     total_in     = total_new;
                     attempt_in   = 6'd0;
                     phase_in     = ST_LOADING;
                  end
                  if (pl_base < PLW'(CAP)) begin
                     wr_en  = 1'b1;
                     pl_in  = pl_base + PLW'(1);
                     crc_in = free ? start_crc : byte_crc;
                  end else begin
                     reject = 1'b1;
                  end
                  // an overflowing last byte still closes the frame
                  if (item.last_byte) begin
                     rp_in      = '0;
                     attempt_in = 6'd1;
                     phase_in   = ST_SENDING;
                  end
               end else begin
                  reject = 1'b1;
               end
            end
            CMD_PULL: begin
               if (phase_ff == ST_SENDING && rp_ff < frame_len) begin
                  tx_valid = 1'b1;
                  tx_byte  = pull_byte;
                  rp_in    = rp_step;
                  if (rp_step >= frame_len) begin
                     tx_last  = 1'b1;
                     wait_in  = 13'd0;
                     phase_in = ST_AWAIT;
                  end
               end else begin
                  reject = 1'b1;
               end
            end
            CMD_ACK: begin
               if (phase_ff == ST_AWAIT) begin
                  if (item.ack_good && item.ack_sequence == frame_seq_ff) begin
                     phase_in = ST_ACKED;
                     if (!tele_ff) begin
                        file_seq_in = file_seq_ff + 8'd1;
                     end
                  end else begin
                     fail_attempt = 1'b1;
                  end
               end else begin
                  reject = 1'b1;
               end
            end
            CMD_TICK: begin
               if (phase_ff == ST_AWAIT) begin
                  wait_in = wait_step;
                  if (wait_step >= cfg.ack_timeout_ticks || cfg.ack_timeout_ticks == 13'd0) begin
                     fail_attempt = 1'b1;
                  end
               end else if (phase_ff == ST_BACKOFF) begin
                  wait_in = wait_step;
                  if (wait_step >= {3'd0, cfg.backoff_ticks}) begin
                     do_resend = 1'b1;
                  end
               end
            end
            default: reject = 1'b1;
         endcase
         if (fail_attempt) begin
            if (attempt_ff >= cfg.max_attempts) begin
               phase_in = ST_FAILED;
            end else begin
               wait_in  = 13'd0;
               phase_in = ST_BACKOFF;
               if (cfg.backoff_ticks == 10'd0) begin
                  do_resend = 1'b1;
               end
            end
         end
         if (do_resend) begin
            attempt_in = attempt_ff + 6'd1;
            rp_in      = '0;
            phase_in   = ST_SENDING;
         end
      end
   end

   assign result.tx_valid       = tx_valid;
   assign result.tx_byte        = tx_byte;
   assign result.tx_last        = tx_last;
   assign result.status         = reject ? ST_REJECT : phase_in;
   assign result.attempt_number = attempt_in;
   assign result.next_sequence  = file_seq_in;

   // read port follows the next read pointer, so rd_data_ff is ready at the next pull
   assign rd_ptr_off = rp_in - RPW'(HEADER_BYTES);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[pl_base[AW-1:0]] <= item.data_byte;
      end
      rd_data_ff <= store_mem[rd_ptr_off[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_IDLE;
         pl_ff        <= '0;
         rp_ff        <= '0;
         crc_ff       <= CRC_PRESET;
         attempt_ff   <= 6'd0;
         wait_ff      <= 13'd0;
         file_seq_ff  <= 8'd0;
         frame_seq_ff <= 8'd0;
         tele_ff      <= 1'b0;
         total_ff     <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         pl_ff        <= pl_in;
         rp_ff        <= rp_in;
         crc_ff       <= crc_in;
         attempt_ff   <= attempt_in;
         wait_ff      <= wait_in;
         file_seq_ff  <= file_seq_in;
         frame_seq_ff <= frame_seq_in;
         tele_ff      <= tele_in;
         total_ff     <= total_in;
      end
   end

endmodule
